// ===== src/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// shared types, constants and the cordic angle table for quaternion to euler
// ----------------------------------------------------------------------------
package qte_pkg;

    // cordic iterations per angle
    localparam int CORDIC_STEPS = 16;

    // widths fixed by the field formats
    localparam int COMP_W  = 16;
    localparam int HEAD_W  = 17;
    localparam int ATT_W   = 15;
    localparam int ANG_W   = 16;
    localparam int OPND_W  = 34;   // cordic operand width at the input
    localparam int FACT_W  = 31;   // sqrt factor width after scaling
    localparam int SQ_W    = 2 * FACT_W;
    localparam int SQRT_BITS = FACT_W;
    localparam int CORDIC_W = 46;  // working width inside the cordic
    localparam int ACC_W   = 26;   // angle accumulator, lsb 2^-16 degree

    // pole test 1000*t against 499*u
    localparam int POLE_NUM = 1000;
    localparam int POLE_DEN = 499;

    // angle constants
    localparam int HALF_TURN_OUT    = 23040;
    localparam int QUARTER_TURN_OUT = 11520;
    localparam int QUARTER_TURN_ACC = 5898240;
    localparam int ROUND_BIAS  = 256;
    localparam int ROUND_SHIFT = 9;

    // normalize until one magnitude reaches 2^NORM_EXP
    localparam int NORM_EXP    = 40;
    localparam int NORM_STAGES = 7;

    // cordic pipeline: input, normalize, quadrant, iterations, rounding
    localparam int CORDIC_LAT = 1 + NORM_STAGES + 1 + CORDIC_STEPS + 1;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2,
        POLE_ZERO  = 2'd3
    } t_pole;

    // one classified item as handed from front to back
    typedef struct packed {
        t_pole                     status;
        logic signed [OPND_W-1:0]  hn;
        logic signed [OPND_W-1:0]  hd;
        logic signed [OPND_W-1:0]  bn;
        logic signed [OPND_W-1:0]  bd;
        logic signed [OPND_W-1:0]  num;
        logic [FACT_W-1:0]         fa;
        logic [FACT_W-1:0]         fb;
    } t_job;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic signed [ACC_W-1:0] angle_step(input logic [4:0] idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            5'd0:  v = 26'sd2949120;
            5'd1:  v = 26'sd1740967;
            5'd2:  v = 26'sd919879;
            5'd3:  v = 26'sd466945;
            5'd4:  v = 26'sd234379;
            5'd5:  v = 26'sd117304;
            5'd6:  v = 26'sd58666;
            5'd7:  v = 26'sd29335;
            5'd8:  v = 26'sd14668;
            5'd9:  v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            5'd20: v = 26'sd4;
            5'd21: v = 26'sd2;
            5'd22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/qte_front.sv =====
// ----------------------------------------------------------------------------
// qte_front
// products, sums, pole test and sqrt factor scaling; five register stages
// ----------------------------------------------------------------------------
module qte_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [qte_pkg::COMP_W-1:0]    i_comp_x,
    input  logic signed [qte_pkg::COMP_W-1:0]    i_comp_y,
    input  logic signed [qte_pkg::COMP_W-1:0]    i_comp_z,
    input  logic signed [qte_pkg::COMP_W-1:0]    i_comp_w,
    input  logic                                 i_full,
    output logic                                 o_push,
    output qte_pkg::t_job                        o_job
);

    localparam int OW = qte_pkg::OPND_W;
    localparam int PW = 44;
    localparam int FW = OW + 1;

    logic en;
    logic [4:0] r_vld;

    logic signed [15:0] r_x1, r_y1, r_z1, r_w1;
    logic signed [31:0] r_sx, r_sy, r_sz, r_sw, r_xy, r_zw, r_yw, r_xz, r_xw, r_yz;
    logic signed [15:0] r_x2, r_w2, r_x3, r_w3, r_x4, r_w4;
    logic signed [OW-1:0] r_unit, r_test;
    logic signed [OW-1:0] r_hn3, r_hd3, r_bn3, r_bd3;
    logic signed [OW-1:0] r_hn4, r_hd4, r_bn4, r_bd4, r_num4;
    logic signed [PW-1:0] r_p1000, r_p499;
    logic signed [FW-1:0] r_fa, r_fb;
    logic                 r_zero;
    qte_pkg::t_job        r_job;
    qte_pkg::t_job        n_job;
    logic [FW-1:0]        n_span;
    logic [1:0]           n_shift;

    assign en         = !r_vld[4] || !i_full;
    assign o_in_stall = !en;
    assign o_push     = r_vld[4] && !i_full;
    assign o_job      = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[3:0], i_in_valid};
        end
    end

    // classification and scaling of the sqrt factors below 2^31
    always_comb begin
        n_span = r_fa | r_fb;
        if (n_span[FW-2]) begin
            n_shift = 2'd3;
        end else if (n_span[FW-3]) begin
            n_shift = 2'd2;
        end else if (n_span[FW-4]) begin
            n_shift = 2'd1;
        end else begin
            n_shift = 2'd0;
        end
        n_job.fa  = qte_pkg::FACT_W'(r_fa >>> n_shift);
        n_job.fb  = qte_pkg::FACT_W'(r_fb >>> n_shift);
        n_job.num = r_num4 >>> n_shift;
        n_job.bn  = r_bn4;
        n_job.bd  = r_bd4;
        if (r_zero) begin
            n_job.status = qte_pkg::POLE_ZERO;
        end else if (r_p1000 > r_p499) begin
            n_job.status = qte_pkg::POLE_NORTH;
        end else if (r_p1000 < -r_p499) begin
            n_job.status = qte_pkg::POLE_SOUTH;
        end else begin
            n_job.status = qte_pkg::POLE_NONE;
        end
        if (n_job.status == qte_pkg::POLE_NORTH || n_job.status == qte_pkg::POLE_SOUTH) begin
            n_job.hn = OW'(r_x4);
            n_job.hd = OW'(r_w4);
        end else begin
            n_job.hn = r_hn4;
            n_job.hd = r_hd4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: input register
            r_x1 <= i_comp_x;
            r_y1 <= i_comp_y;
            r_z1 <= i_comp_z;
            r_w1 <= i_comp_w;
            // stage 2: products
            r_sx <= 32'(r_x1) * 32'(r_x1);
            r_sy <= 32'(r_y1) * 32'(r_y1);
            r_sz <= 32'(r_z1) * 32'(r_z1);
            r_sw <= 32'(r_w1) * 32'(r_w1);
            r_xy <= 32'(r_x1) * 32'(r_y1);
            r_zw <= 32'(r_z1) * 32'(r_w1);
            r_yw <= 32'(r_y1) * 32'(r_w1);
            r_xz <= 32'(r_x1) * 32'(r_z1);
            r_xw <= 32'(r_x1) * 32'(r_w1);
            r_yz <= 32'(r_y1) * 32'(r_z1);
            r_x2 <= r_x1;
            r_w2 <= r_w1;
            // stage 3: magnitude, pole test and atan2 operands
            r_unit <= OW'(r_sx) + OW'(r_sy) + OW'(r_sz) + OW'(r_sw);
            r_test <= OW'(r_xy) + OW'(r_zw);
            r_hn3  <= (OW'(r_yw) - OW'(r_xz)) <<< 1;
            r_hd3  <= OW'(r_sx) - OW'(r_sy) - OW'(r_sz) + OW'(r_sw);
            r_bn3  <= (OW'(r_xw) - OW'(r_yz)) <<< 1;
            r_bd3  <= OW'(r_sy) - OW'(r_sx) - OW'(r_sz) + OW'(r_sw);
            r_x3   <= r_x2;
            r_w3   <= r_w2;
            // stage 4: scaled pole comparison terms and sqrt factors
            r_p1000 <= PW'(r_test) * PW'(qte_pkg::POLE_NUM);
            r_p499  <= PW'(r_unit) * PW'(qte_pkg::POLE_DEN);
            r_fa    <= FW'(r_unit) - (FW'(r_test) <<< 1);
            r_fb    <= FW'(r_unit) + (FW'(r_test) <<< 1);
            r_num4  <= r_test <<< 1;
            r_zero  <= (r_unit == '0);
            r_hn4   <= r_hn3;
            r_hd4   <= r_hd3;
            r_bn4   <= r_bn3;
            r_bd4   <= r_bd3;
            r_x4    <= r_x3;
            r_w4    <= r_w3;
            // stage 5: classified item
            r_job   <= n_job;
        end
    end

endmodule

// ===== src/qte_queue.sv =====
// ----------------------------------------------------------------------------
// qte_queue
// small fifo of classified items between front and back
// ----------------------------------------------------------------------------
module qte_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qte_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output qte_pkg::t_job o_job
);

    localparam int PW = qte_pkg::QPTR_W;

    qte_pkg::t_job r_mem [0:qte_pkg::QDEPTH-1];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (PW+1)'(qte_pkg::QDEPTH));
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== src/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic
// pipelined vectoring cordic: angle of (x, y) in 1/128 degree
// ----------------------------------------------------------------------------
module qte_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [qte_pkg::OPND_W-1:0]    i_y,
    input  logic signed [qte_pkg::OPND_W-1:0]    i_x,
    output logic signed [qte_pkg::ANG_W-1:0]     o_angle
);

    localparam int CW = qte_pkg::CORDIC_W;
    localparam int AW = qte_pkg::ACC_W;
    localparam int NS = qte_pkg::NORM_STAGES;
    localparam int NI = qte_pkg::CORDIC_STEPS;
    localparam int QW = AW - qte_pkg::ROUND_SHIFT;

    logic signed [CW-1:0] r_nx [0:NS];
    logic signed [CW-1:0] r_ny [0:NS];
    logic                 r_nz [0:NS];
    logic signed [CW-1:0] r_cx [0:NI];
    logic signed [CW-1:0] r_cy [0:NI];
    logic signed [AW-1:0] r_acc [0:NI];
    logic                 r_cz [0:NI];
    logic signed [qte_pkg::ANG_W-1:0] r_angle;

    logic signed [CW-1:0] n_qx, n_qy;
    logic signed [AW-1:0] n_qacc;
    logic signed [AW-1:0] n_sum;
    logic signed [QW-1:0] n_q;
    logic signed [qte_pkg::ANG_W-1:0] n_angle;

    assign o_angle = r_angle;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx[0] <= CW'(i_x);
            r_ny[0] <= CW'(i_y);
            r_nz[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    // binary search on the left shift, then one final doubling
    for (genvar j = 0; j < NS; j++) begin : g_norm
        localparam int SH  = (j < NS - 1) ? (2 ** (NS - 2 - j)) : 1;
        localparam int LIM = (j < NS - 1) ? (qte_pkg::NORM_EXP - SH) : qte_pkg::NORM_EXP;
        logic [CW-1:0] w_ax, w_ay;
        logic          w_fit;
        always_comb begin
            w_ax  = r_nx[j][CW-1] ? CW'(-r_nx[j]) : CW'(r_nx[j]);
            w_ay  = r_ny[j][CW-1] ? CW'(-r_ny[j]) : CW'(r_ny[j]);
            w_fit = (w_ax < (CW'(1) << LIM)) && (w_ay < (CW'(1) << LIM));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nx[j+1] <= w_fit ? (r_nx[j] <<< SH) : r_nx[j];
                r_ny[j+1] <= w_fit ? (r_ny[j] <<< SH) : r_ny[j];
                r_nz[j+1] <= r_nz[j];
            end
        end
    end

    // fold the left half plane onto the right
    always_comb begin
        n_qx   = r_nx[NS];
        n_qy   = r_ny[NS];
        n_qacc = '0;
        if (r_nx[NS][CW-1]) begin
            if (!r_ny[NS][CW-1]) begin
                n_qx   = r_ny[NS];
                n_qy   = -r_nx[NS];
                n_qacc = AW'(qte_pkg::QUARTER_TURN_ACC);
            end else begin
                n_qx   = -r_ny[NS];
                n_qy   = r_nx[NS];
                n_qacc = -AW'(qte_pkg::QUARTER_TURN_ACC);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0]  <= n_qx;
            r_cy[0]  <= n_qy;
            r_acc[0] <= n_qacc;
            r_cz[0]  <= r_nz[NS];
        end
    end

    for (genvar i = 0; i < NI; i++) begin : g_iter
        localparam logic signed [AW-1:0] STEP = qte_pkg::angle_step(5'(i));
        logic signed [CW-1:0] w_dx, w_dy;
        always_comb begin
            w_dx = r_cy[i] >>> i;
            w_dy = r_cx[i] >>> i;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_cy[i][CW-1]) begin
                    r_cx[i+1]  <= r_cx[i] + w_dx;
                    r_cy[i+1]  <= r_cy[i] - w_dy;
                    r_acc[i+1] <= r_acc[i] + STEP;
                end else begin
                    r_cx[i+1]  <= r_cx[i] - w_dx;
                    r_cy[i+1]  <= r_cy[i] + w_dy;
                    r_acc[i+1] <= r_acc[i] - STEP;
                end
                r_cz[i+1] <= r_cz[i];
            end
        end
    end

    // round to 1/128 degree and limit to a half turn
    always_comb begin
        n_sum = r_acc[NI] + AW'(qte_pkg::ROUND_BIAS);
        n_q   = QW'(n_sum >>> qte_pkg::ROUND_SHIFT);
        if (r_cz[NI]) begin
            n_angle = '0;
        end else if (n_q > QW'(qte_pkg::HALF_TURN_OUT)) begin
            n_angle = qte_pkg::ANG_W'(qte_pkg::HALF_TURN_OUT);
        end else if (n_q < -QW'(qte_pkg::HALF_TURN_OUT)) begin
            n_angle = -qte_pkg::ANG_W'(qte_pkg::HALF_TURN_OUT);
        end else begin
            n_angle = qte_pkg::ANG_W'(n_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

endmodule

// ===== src/qte_back.sv =====
// ----------------------------------------------------------------------------
// qte_back
// sqrt factor product, pipelined integer sqrt, three cordics, output register
// ----------------------------------------------------------------------------
module qte_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  qte_pkg::t_job                        i_q_job,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [qte_pkg::HEAD_W-1:0]    o_heading_deg,
    output logic signed [qte_pkg::ATT_W-1:0]     o_attitude_deg,
    output logic signed [qte_pkg::ANG_W-1:0]     o_bank_deg,
    output logic [1:0]                           o_pole_status
);

    localparam int SB  = qte_pkg::SQRT_BITS;
    localparam int SW  = qte_pkg::SQ_W;
    localparam int CL  = qte_pkg::CORDIC_LAT;
    localparam int LAT = 2 + SB + CL;
    localparam int OW  = qte_pkg::OPND_W;
    localparam int HW  = qte_pkg::HEAD_W;
    localparam int TW  = qte_pkg::ATT_W;
    localparam int GW  = qte_pkg::ANG_W;

    logic en;
    logic [LAT-1:0] r_vld;

    qte_pkg::t_job r_a_job;
    qte_pkg::t_job r_sjob [0:SB];
    logic [SW-1:0] r_rem [0:SB];
    logic [SW-1:0] r_res [0:SB];
    qte_pkg::t_pole r_cst [0:CL-1];

    logic signed [GW-1:0] w_head, w_att, w_bank;
    logic signed [OW-1:0] w_root;

    logic                 r_out_valid;
    logic signed [HW-1:0] r_head;
    logic signed [TW-1:0] r_att;
    logic signed [GW-1:0] r_bank;
    qte_pkg::t_pole       r_stat;
    logic signed [HW-1:0] n_head;
    logic signed [TW-1:0] n_att;
    logic signed [GW-1:0] n_bank;

    assign en             = !r_out_valid || !i_out_stall;
    assign o_pop          = en && i_q_valid;
    assign o_out_valid    = r_out_valid;
    assign o_heading_deg  = r_head;
    assign o_attitude_deg = r_att;
    assign o_bank_deg     = r_bank;
    assign o_pole_status  = r_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[LAT-2:0], i_q_valid};
            r_out_valid <= r_vld[LAT-1];
        end
    end

    // item register and factor product
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_job  <= i_q_job;
            r_sjob[0] <= r_a_job;
            r_rem[0] <= SW'(r_a_job.fa) * SW'(r_a_job.fb);
            r_res[0] <= '0;
        end
    end

    // digit-by-digit square root, one result bit per stage
    for (genvar k = 0; k < SB; k++) begin : g_sqrt
        localparam int BE = 2 * (SB - 1 - k);
        logic [SW:0] w_sum;
        always_comb begin
            w_sum = {1'b0, r_res[k]} + ((SW+1)'(1) << BE);
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                if ({1'b0, r_rem[k]} >= w_sum) begin
                    r_rem[k+1] <= r_rem[k] - w_sum[SW-1:0];
                    r_res[k+1] <= (r_res[k] >> 1) + (SW'(1) << BE);
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_res[k+1] <= r_res[k] >> 1;
                end
                r_sjob[k+1] <= r_sjob[k];
            end
        end
    end

    assign w_root = OW'({1'b0, r_res[SB][SB-1:0]});

    qte_cordic u_head (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_sjob[SB].hn),
        .i_x     (r_sjob[SB].hd),
        .o_angle (w_head)
    );

    qte_cordic u_att (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_sjob[SB].num),
        .i_x     (w_root),
        .o_angle (w_att)
    );

    qte_cordic u_bank (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_sjob[SB].bn),
        .i_x     (r_sjob[SB].bd),
        .o_angle (w_bank)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cst[0] <= r_sjob[SB].status;
        end
    end

    for (genvar c = 1; c < CL; c++) begin : g_stat
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cst[c] <= r_cst[c-1];
            end
        end
    end

    // pick the final angles by pole status
    always_comb begin
        case (r_cst[CL-1])
            qte_pkg::POLE_NORTH: begin
                n_head = HW'(w_head) <<< 1;
                n_att  = TW'(qte_pkg::QUARTER_TURN_OUT);
                n_bank = '0;
            end
            qte_pkg::POLE_SOUTH: begin
                n_head = -(HW'(w_head) <<< 1);
                n_att  = -TW'(qte_pkg::QUARTER_TURN_OUT);
                n_bank = '0;
            end
            qte_pkg::POLE_ZERO: begin
                n_head = '0;
                n_att  = '0;
                n_bank = '0;
            end
            default: begin
                n_head = HW'(w_head);
                if (w_att > GW'(qte_pkg::QUARTER_TURN_OUT)) begin
                    n_att = TW'(qte_pkg::QUARTER_TURN_OUT);
                end else if (w_att < -GW'(qte_pkg::QUARTER_TURN_OUT)) begin
                    n_att = -TW'(qte_pkg::QUARTER_TURN_OUT);
                end else begin
                    n_att = TW'(w_att);
                end
                n_bank = w_bank;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_head <= n_head;
            r_att  <= n_att;
            r_bank <= n_bank;
            r_stat <= r_cst[CL-1];
        end
    end

endmodule

// ===== src/quaternion_to_euler_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_top: quaternion to heading, attitude and bank
// throughput one quaternion per cycle while the front and the back are not stalled
// pipeline depth set mostly by the 31-stage square root and the cordic
// iteration stages
// synchronous active-low reset clears valid bits, queue pointers and queue count only
// ----------------------------------------------------------------------------
module quaternion_to_euler_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input beats
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_comp_x,
    input  logic signed [15:0] i_comp_y,
    input  logic signed [15:0] i_comp_z,
    input  logic signed [15:0] i_comp_w,
    // result beats
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [16:0] o_heading_deg,
    output logic signed [14:0] o_attitude_deg,
    output logic signed [15:0] o_bank_deg,
    output logic [1:0]         o_pole_status
);

    // front to queue
    logic          w_push;
    logic          w_full;
    qte_pkg::t_job w_front_job;
    // queue to back
    logic          w_q_valid;
    logic          w_pop;
    qte_pkg::t_job w_q_job;

    // front: products, magnitude, pole test and sqrt factor scaling;
    // the whole front freezes only when its last stage holds a beat
    // and the queue is full
    qte_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_comp_x   (i_comp_x),
        .i_comp_y   (i_comp_y),
        .i_comp_z   (i_comp_z),
        .i_comp_w   (i_comp_w),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_front_job)
    );

    // queue decouples the front stall from the output stall
    qte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_full),
        .o_job   (w_q_job)
    );

    // back: square root for asin, three cordics and the output register;
    // it advances whenever the output register is empty or being taken
    qte_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_job        (w_q_job),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_heading_deg  (o_heading_deg),
        .o_attitude_deg (o_attitude_deg),
        .o_bank_deg     (o_bank_deg),
        .o_pole_status  (o_pole_status)
    );

`ifndef SYNTHESIS
    // a held result beat must freeze the back, so nothing leaves the queue
    a_no_pop_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !w_pop)
        else $error("queue popped while the result beat was held");

    // zero quaternion gives zero angles
    a_zero_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pole_status == qte_pkg::POLE_ZERO) |->
        (o_heading_deg == '0 && o_attitude_deg == '0 && o_bank_deg == '0))
        else $error("zero quaternion with nonzero angles");

    // north pole pins attitude and clears bank
    a_north_pole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pole_status == qte_pkg::POLE_NORTH) |->
        (o_attitude_deg == 15'sd11520 && o_bank_deg == '0))
        else $error("north pole beat with wrong attitude or bank");
`endif

endmodule

// ===== tb/sv/quaternion_to_euler_top_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_top_tb
// drives quaternion beats, predicts heading, attitude, bank and pole status
// with a local cordic model and checks every result beat in order
// ----------------------------------------------------------------------------
module quaternion_to_euler_top_tb;

    // one predicted euler result
    typedef struct {
        logic signed [16:0] heading;
        logic signed [14:0] attitude;
        logic signed [15:0] bank;
        qte_pkg::t_pole     status;
    } t_euler;

    // atan(2^-i) in 2^-16 degree
    function automatic longint atan_step(int idx);
        longint tbl [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                             58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                             229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return tbl[idx];
    endfunction

    function automatic longint sat(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // angle of (vx, vy) in 1/128 degree, by the block's cordic
    function automatic longint cordic_angle(longint vy, longint vx);
        longint acc, t, dx, dy;
        acc = 0;
        if (vx == 0 && vy == 0) return 0;
        while ((vx < 0 ? -vx : vx) < (64'sd1 <<< 40) &&
               (vy < 0 ? -vy : vy) < (64'sd1 <<< 40)) begin
            vx = vx * 2;
            vy = vy * 2;
        end
        if (vx < 0) begin
            t = vx;
            if (vy >= 0) begin
                vx = vy; vy = -t; acc = qte_pkg::QUARTER_TURN_ACC;
            end else begin
                vx = -vy; vy = t; acc = -qte_pkg::QUARTER_TURN_ACC;
            end
        end
        for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 24; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx += dx; vy -= dy; acc += atan_step(i);
            end else begin
                vx -= dx; vy += dy; acc -= atan_step(i);
            end
        end
        return sat((acc + qte_pkg::ROUND_BIAS) >>> qte_pkg::ROUND_SHIFT,
                   qte_pkg::HALF_TURN_OUT);
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic t_euler quat_to_euler(logic signed [15:0] qx, logic signed [15:0] qy,
                                             logic signed [15:0] qz, logic signed [15:0] qw);
        longint x, y, z, w, sx, sy, sz, sw, mag2, test, num, fa, fb, c;
        t_euler r;
        x = qx; y = qy; z = qz; w = qw;
        sx = x * x; sy = y * y; sz = z * z; sw = w * w;
        mag2 = sx + sy + sz + sw;
        test = x * y + z * w;
        r.heading = 0; r.attitude = 0; r.bank = 0; r.status = qte_pkg::POLE_NONE;
        if (mag2 == 0) begin
            r.status = qte_pkg::POLE_ZERO;
        end else if (qte_pkg::POLE_NUM * test > qte_pkg::POLE_DEN * mag2) begin
            r.heading  = 17'(2 * cordic_angle(x, w));
            r.attitude = 15'(qte_pkg::QUARTER_TURN_OUT);
            r.status   = qte_pkg::POLE_NORTH;
        end else if (qte_pkg::POLE_NUM * test < -qte_pkg::POLE_DEN * mag2) begin
            r.heading  = 17'(-2 * cordic_angle(x, w));
            r.attitude = 15'(-qte_pkg::QUARTER_TURN_OUT);
            r.status   = qte_pkg::POLE_SOUTH;
        end else begin
            num = 2 * test; fa = mag2 - num; fb = mag2 + num;
            while (fa >= (64'sd1 <<< 31) || fb >= (64'sd1 <<< 31)) begin
                fa = fa >>> 1; fb = fb >>> 1; num = num >>> 1;
            end
            if (fa < 0) fa = 0;
            if (fb < 0) fb = 0;
            c = floor_sqrt(fa * fb);
            r.heading  = 17'(cordic_angle(2 * y * w - 2 * x * z, sx - sy - sz + sw));
            r.attitude = 15'(sat(cordic_angle(num, c), qte_pkg::QUARTER_TURN_OUT));
            r.bank     = 16'(cordic_angle(2 * x * w - 2 * y * z, -sx + sy - sz + sw));
        end
        return r;
    endfunction

    // in-order store of predicted results
    class euler_board;
        t_euler pending[$];
        int     errors = 0;

        function void note_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                                logic signed [15:0] qz, logic signed [15:0] qw);
            pending.push_back(quat_to_euler(qx, qy, qz, qw));
        endfunction

        function void check_euler(logic signed [16:0] h, logic signed [14:0] a,
                                  logic signed [15:0] b, logic [1:0] s);
            t_euler e;
            if (pending.size() == 0) begin
                $error("result beat with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (h !== e.heading) begin
                $error("heading_deg expected %0d got %0d", e.heading, h); errors++;
            end
            if (a !== e.attitude) begin
                $error("attitude_deg expected %0d got %0d", e.attitude, a); errors++;
            end
            if (b !== e.bank) begin
                $error("bank_deg expected %0d got %0d", e.bank, b); errors++;
            end
            if (s !== e.status) begin
                $error("pole_status expected %0d got %0d", e.status, s); errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_comp_x, i_comp_y, i_comp_z, i_comp_w;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [16:0] o_heading_deg;
    logic signed [14:0] o_attitude_deg;
    logic signed [15:0] o_bank_deg;
    logic [1:0]         o_pole_status;

    quaternion_to_euler_top uut (.*);

    euler_board board = new();
    longint     cycle_count = 0;
    // idling is off during the calm stretch
    bit         calm = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: 1600+ items at worst gap and stall, plus pipeline depth
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random stall, check on each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                board.check_euler(o_heading_deg, o_attitude_deg, o_bank_deg, o_pole_status);
            i_out_stall <= !calm && ($urandom_range(99) < 23);
        end
    end

    // send one quaternion beat, with a random gap ahead of it
    task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                             logic signed [15:0] qz, logic signed [15:0] qw);
        while (!calm && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_comp_x <= qx; i_comp_y <= qy; i_comp_z <= qz; i_comp_w <= qw;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_quat(qx, qy, qz, qw);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    // random quaternion: some small magnitudes, some near poles, the rest raw noise
    task automatic send_random();
        int                 kind;
        logic signed [15:0] a, b, c, d;
        kind = int'($urandom_range(9));
        a = 16'($urandom); b = 16'($urandom); c = 16'($urandom); d = 16'($urandom);
        if (kind < 4) begin
            // small magnitudes exercise the normalize path
            a = a >>> $urandom_range(15); b = b >>> $urandom_range(15);
            c = c >>> $urandom_range(15); d = d >>> $urandom_range(15);
        end else if (kind < 6) begin
            // near a pole: x ~ y and z ~ w (or negated)
            b = 16'(a + $signed(16'($urandom_range(63))) - 16'sd32);
            d = 16'(($urandom_range(1) ? c : -c) + $signed(16'($urandom_range(15)))
                    - 16'sd8);
            if ($urandom_range(1)) b = -b;
        end
        send_quat(a, b, c, d);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_comp_x   <= '0; i_comp_y <= '0; i_comp_z <= '0; i_comp_w <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, identity, extremes, both poles, axis rotations
        send_quat(0, 0, 0, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(0, 0, 0, -16384);
        send_quat(16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(-32768, 32767, -32768, 32767);
        send_quat(11585, 11585, 0, 0);       // north pole
        send_quat(11585, -11585, 0, 0);      // south pole
        send_quat(8192, 8192, 8192, 8192);   // north pole via z*w
        send_quat(8192, -8192, -8192, 8192); // south pole
        send_quat(1, 1, 0, 0);               // tiny north pole
        send_quat(0, 0, 0, 1);
        send_quat(-1, 0, 0, 0);
        send_quat(0, 0, -1, 1);
        send_quat(100, 99, 0, 0);            // just over the pole limit
        send_quat(1000, 998, 0, 1);
        send_quat(5000, 2000, -3000, 7000);

        // pause the sender until the pipeline is empty
        drain_results();

        for (int n = 0; n < 1600; n++) begin
            calm = (n >= 600 && n < 900);
            send_random();
        end
        calm = 0;

        drain_results();
        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== files.f =====
src/qte_pkg.sv
src/qte_front.sv
src/qte_queue.sv
src/qte_cordic.sv
src/qte_back.sv
src/quaternion_to_euler_top.sv
tb/sv/quaternion_to_euler_top_tb.sv
